// File: src/mspwm_pkg.sv
package mspwm_pkg;

   // event kinds
   typedef enum logic [1:0] {
      CMD_PULSE  = 2'd0,
      CMD_PWM    = 2'd1,
      CMD_SAMPLE = 2'd2
   } cmd_type;

   // configuration register indexes
   typedef enum logic [2:0] {
      REG_GAIN_P          = 3'd0,
      REG_GAIN_I          = 3'd1,
      REG_GAIN_D          = 3'd2,
      REG_INTEGRAL_LIMIT  = 3'd3,
      REG_PWM_PERIOD      = 3'd4,
      REG_SAMPLES_PER_UPD = 3'd5,
      REG_SPEED_PER_PULSE = 3'd6
   } reg_index_type;

   localparam int GAIN_FRAC_BITS = 8;
   localparam int TALLY_W        = 13;
   localparam int SPEED_W        = 16;
   localparam int DUTY_W         = 7;
   localparam int ERR_W          = 17;
   localparam int ACC_W          = 16;
   localparam int PROD_W         = TALLY_W + 8;
   localparam int SUM_W          = 37;
   localparam int Q_W            = SUM_W - GAIN_FRAC_BITS;

   localparam logic [TALLY_W-1:0] PULSE_MAX  = 13'd6553;
   localparam logic [DUTY_W-1:0]  DUTY_MAX   = 7'd100;
   localparam logic [DUTY_W-1:0]  DUTY_RESET = 7'd30;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [14:0] integral_limit;
      logic [7:0]  pwm_period;
      logic [3:0]  samples_per_update;
      logic [7:0]  speed_per_pulse;
   } cfg_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] setpoint;
      logic       run_enable;
   } evt_type;

   typedef struct packed {
      logic               pwm_out;
      logic [DUTY_W-1:0]  duty;
      logic [SPEED_W-1:0] measured_speed;
      logic               updated;
   } rsp_type;

   typedef struct packed {
      logic [ERR_W-1:0]  err;
      logic [ACC_W-1:0]  acc;
      logic [DUTY_W-1:0] duty;
   } pid_out_type;

endpackage

// File: src/mspwm_pid.sv
module mspwm_pid import mspwm_pkg::*; (
   input  cfg_type                  cfg,
   input  logic [7:0]               setpoint,
   input  logic [SPEED_W-1:0]       speed,
   input  logic signed [ACC_W-1:0]  acc,
   input  logic signed [ERR_W-1:0]  prior,
   output pid_out_type              pid
);

   logic signed [ERR_W-1:0] err;
   logic signed [17:0]      acc_sum;
   logic signed [17:0]      lim_pos;
   logic signed [17:0]      lim_neg;
   logic signed [17:0]      acc_clamped;
   logic signed [ACC_W-1:0] acc_new;
   logic signed [17:0]      diff;
   logic signed [33:0]      p_term;
   logic signed [32:0]      i_term;
   logic signed [34:0]      d_term;
   logic signed [SUM_W-1:0] sum;
   logic [Q_W-1:0]          q;
   logic [DUTY_W-1:0]       duty_new;

   always_comb begin
      err     = $signed({9'b0, setpoint}) - $signed({1'b0, speed});
      acc_sum = $signed({{2{acc[ACC_W-1]}}, acc}) + $signed({err[ERR_W-1], err});
      lim_pos = $signed({3'b0, cfg.integral_limit});
      lim_neg = -lim_pos;
      if (acc_sum > lim_pos) begin
         acc_clamped = lim_pos;
      end else if (acc_sum < lim_neg) begin
         acc_clamped = lim_neg;
      end else begin
         acc_clamped = acc_sum;
      end
      acc_new = acc_clamped[ACC_W-1:0];
      diff    = $signed({err[ERR_W-1], err}) - $signed({prior[ERR_W-1], prior});

      p_term = $signed({1'b0, cfg.gain_p}) * err;
      i_term = $signed({1'b0, cfg.gain_i}) * acc_new;
      d_term = $signed({1'b0, cfg.gain_d}) * diff;
      sum    = SUM_W'(p_term) + SUM_W'(i_term) + SUM_W'(d_term);

      // truncating shift of the sum, then saturate (a negative sum gives zero)
      q = sum[SUM_W-1:GAIN_FRAC_BITS];
      if (sum[SUM_W-1]) begin
         duty_new = '0;
      end else if (q > Q_W'(DUTY_MAX)) begin
         duty_new = DUTY_MAX;
      end else begin
         duty_new = q[DUTY_W-1:0];
      end

      pid.err  = err;
      pid.acc  = acc_new;
      pid.duty = duty_new;
   end

endmodule

// File: src/mspwm_core.sv
module mspwm_core import mspwm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic [7:0] spp_next,
   input  logic       fire,
   input  evt_type    evt,
   output rsp_type    rsp
);

   logic [TALLY_W-1:0]      tally_ff, tally_in;
   logic [3:0]              sphase_ff, sphase_in;
   logic [7:0]              pphase_ff, pphase_in;
   logic [DUTY_W-1:0]       duty_ff, duty_in;
   logic [SPEED_W-1:0]      speed_ff, speed_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ERR_W-1:0] prior_ff, prior_in;
   logic                    level_ff, level_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;

   logic [SPEED_W-1:0] speed_meas;
   logic [7:0]         pphase_step;
   logic [3:0]         sphase_step;
   logic               do_update;
   pid_out_type        pid;

   // prod_ff always equals tally_ff * speed_per_pulse
   assign speed_meas = (|prod_ff[PROD_W-1:SPEED_W]) ? '1 : prod_ff[SPEED_W-1:0];

   mspwm_pid u_pid (
      .cfg      (cfg),
      .setpoint (evt.setpoint),
      .speed    (speed_meas),
      .acc      (acc_ff),
      .prior    (prior_ff),
      .pid      (pid)
   );

   always_comb begin
      tally_in    = tally_ff;
      sphase_in   = sphase_ff;
      pphase_in   = pphase_ff;
      duty_in     = duty_ff;
      speed_in    = speed_ff;
      acc_in      = acc_ff;
      prior_in    = prior_ff;
      level_in    = level_ff;
      do_update   = 1'b0;
      pphase_step = pphase_ff + 8'd1;
      sphase_step = sphase_ff + 4'd1;
      if (fire) begin
         case (evt.cmd)
            CMD_PULSE: begin
               if (tally_ff < PULSE_MAX) tally_in = tally_ff + 1'b1;
            end
            CMD_PWM: begin
               if (pphase_step >= cfg.pwm_period) begin
                  pphase_in = '0;
               end else begin
                  pphase_in = pphase_step;
               end
               level_in = evt.run_enable && (pphase_in < {1'b0, duty_ff});
            end
            CMD_SAMPLE: begin
               if (sphase_step >= cfg.samples_per_update) begin
                  sphase_in = '0;
                  do_update = 1'b1;
               end else begin
                  sphase_in = sphase_step;
               end
            end
            default: ;
         endcase
      end
      if (do_update) begin
         speed_in = speed_meas;
         tally_in = '0;
         if (evt.run_enable) begin
            duty_in  = pid.duty;
            acc_in   = $signed(pid.acc);
            prior_in = $signed(pid.err);
         end else begin
            duty_in  = '0;
            acc_in   = '0;
            prior_in = '0;
         end
      end
      prod_in = PROD_W'(tally_in) * PROD_W'(spp_next);
   end

   always_comb begin
      rsp.pwm_out        = level_in;
      rsp.duty           = duty_in;
      rsp.measured_speed = speed_in;
      rsp.updated        = do_update;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff  <= '0;
         sphase_ff <= '0;
         pphase_ff <= '0;
         duty_ff   <= DUTY_RESET;
         speed_ff  <= '0;
         acc_ff    <= '0;
         prior_ff  <= '0;
         level_ff  <= 1'b0;
         prod_ff   <= '0;
      end else begin
         tally_ff  <= tally_in;
         sphase_ff <= sphase_in;
         pphase_ff <= pphase_in;
         duty_ff   <= duty_in;
         speed_ff  <= speed_in;
         acc_ff    <= acc_in;
         prior_ff  <= prior_in;
         level_ff  <= level_in;
         prod_ff   <= prod_in;
      end
   end

   a_run_off_clears: assert property (@(posedge clock) disable iff (reset)
      do_update && !evt.run_enable |=> duty_ff == '0 && acc_ff == '0 && prior_ff == '0)
      else $error("run off update did not clear controller state");

   a_update_clears_tally: assert property (@(posedge clock) disable iff (reset)
      do_update |=> tally_ff == '0 && speed_ff == $past(speed_meas))
      else $error("update did not latch speed and clear tally");

   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(tally_ff) && $stable(duty_ff) && $stable(pphase_ff)
                && $stable(level_ff))
      else $error("state moved without an item");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      fire |=> duty_ff <= DUTY_MAX)
      else $error("duty above 100");

endmodule

// File: src/motor_speed_pid_with_pwm_unit.sv
// Motor speed controller: encoder pulse counter, PWM generator and PID loop.
// Input channel (req_*): one event per item, req_cmd selects encoder pulse,
// PWM tick or sample tick; speed setpoint and run enable ride along.
// Result channel (rsp_*): exactly one item per event, carrying the PWM level,
// current duty, last measured speed and a flag for a PID update.
// Config port (csr_*): writes take effect at the clock edge with
// csr_write_en high; only write while no item is in flight.
// Path: an accepted item goes from the input register to the result register.
// Throughput: one item per cycle while rsp_ready stays high; the event
// decode, speed saturation and PID (three parallel multiplies, sum, clamp)
// settle combinationally between the input register and the result register.
// Stall: the result register holds while rsp_ready is low; the input
// register still takes one more item, then req_ready drops.
// Reset: gains and limits return to defaults, duty to 30, all counters,
// speed, integral and prior error to zero, PWM level low.
module motor_speed_pid_with_pwm_unit import mspwm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_cmd,
   input  logic [7:0]         req_setpoint,
   input  logic               req_run_enable,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_pwm_out,
   output logic [DUTY_W-1:0]  rsp_duty,
   output logic [SPEED_W-1:0] rsp_measured_speed,
   output logic               rsp_updated,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   cfg_type cfg_ff, cfg_in;
   evt_type evt_ff;
   rsp_type rsp_ff, rsp_next;
   logic    s1_valid_ff, s1_valid_in;
   logic    out_valid_ff, out_valid_in;
   logic    out_free;
   logic    fire;
   logic    req_take;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            REG_GAIN_P:          cfg_in.gain_p = csr_wdata;
            REG_GAIN_I:          cfg_in.gain_i = csr_wdata;
            REG_GAIN_D:          cfg_in.gain_d = csr_wdata;
            REG_INTEGRAL_LIMIT:  cfg_in.integral_limit = csr_wdata[14:0];
            REG_PWM_PERIOD:      cfg_in.pwm_period = csr_wdata[7:0];
            REG_SAMPLES_PER_UPD: cfg_in.samples_per_update = csr_wdata[3:0];
            REG_SPEED_PER_PULSE: cfg_in.speed_per_pulse = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      out_free     = !out_valid_ff || rsp_ready;
      fire         = s1_valid_ff && out_free;
      req_ready    = !s1_valid_ff || out_free;
      req_take     = req_valid && req_ready;
      s1_valid_in  = req_take || (s1_valid_ff && !fire);
      out_valid_in = fire || (out_valid_ff && !rsp_ready);
   end

   mspwm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .spp_next (cfg_in.speed_per_pulse),
      .fire     (fire),
      .evt      (evt_ff),
      .rsp      (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p             <= 16'd371;
         cfg_ff.gain_i             <= 16'd72;
         cfg_ff.gain_d             <= 16'd31;
         cfg_ff.integral_limit     <= 15'd180;
         cfg_ff.pwm_period         <= 8'd100;
         cfg_ff.samples_per_update <= 4'd4;
         cfg_ff.speed_per_pulse    <= 8'd10;
         s1_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         evt_ff.cmd        <= req_cmd;
         evt_ff.setpoint   <= req_setpoint;
         evt_ff.run_enable <= req_run_enable;
      end
      if (fire) rsp_ff <= rsp_next;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pwm_out        = rsp_ff.pwm_out;
   assign rsp_duty           = rsp_ff.duty;
   assign rsp_measured_speed = rsp_ff.measured_speed;
   assign rsp_updated        = rsp_ff.updated;

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |=> s1_valid_ff && $stable(evt_ff))
      else $error("input stage lost an item while blocked");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |-> !fire)
      else $error("result overwritten while stalled");

   a_fire_to_out: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed item did not reach the result register");

endmodule
